@@ design/bitmap_page_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// bitmap page allocator assertion macros
// concurrent checks on clk with arst_n as the disable condition; empty bodies
// when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define BPA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// antecedent implies consequent in the next cycle
`define BPA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BPA_ASSERT_IMP(label, ante, cons, msg)
`define BPA_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

@@ design/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types, codes and default sizes of the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

	// default sizes
	localparam int NUM_PAGES_DEF      = 16384;
	localparam int WORD_BITS_DEF      = 32;
	localparam int RESERVED_PAGES_DEF = 256;

	// field widths of the request and response
	localparam int CNT_W  = 15;
	localparam int PAGE_W = 14;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} bpa_op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_NOMEM = 2'd1,
		STAT_BAD   = 2'd2
	} bpa_status_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN,
		ST_APPLY_RD,
		ST_APPLY,
		ST_DONE
	} bpa_state_t;

	// controls for the shared word unit
	typedef struct packed {
		logic use_lo;   // bits below lo_b are outside the range
		logic use_hi;   // bits above hi_b are outside the range
		logic set_op;   // apply: set the range, else clear it
	} wu_cmd_t;

endpackage

@@ design/bpa_req_if.sv @@
// ----------------------------------------------------------------------------
// bpa_req_if
// request channel: operation, page count and first page of a free
// ----------------------------------------------------------------------------
interface bpa_req_if import bpa_pkg::*; ();
	logic                valid;
	logic                ready;
	bpa_op_t             op;
	logic [CNT_W-1:0]    page_count;
	logic [PAGE_W-1:0]   page_index;

	modport source (output valid, op, page_count, page_index, input ready);
	modport sink (input valid, op, page_count, page_index, output ready);
endinterface

@@ design/bpa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bpa_rsp_if
// response channel: status, first page of an allocated run, pages in use
// ----------------------------------------------------------------------------
interface bpa_rsp_if import bpa_pkg::*; ();
	logic                valid;
	logic                ready;
	bpa_status_t         status;
	logic [PAGE_W-1:0]   first_page;
	logic [CNT_W-1:0]    used_pages;

	modport source (output valid, status, first_page, used_pages, input ready);
	modport sink (input valid, status, first_page, used_pages, output ready);
endinterface

@@ design/bpa_ram.sv @@
// ----------------------------------------------------------------------------
// bpa_ram
// generic simple dual-port ram: one write port, one read port, registered read
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/bpa_word_unit.sv @@
// ----------------------------------------------------------------------------
// bpa_word_unit
// shared per-word unit: free-run search over one map word, and the set or
// clear of a page range within it with a count of the bits that were set
// ----------------------------------------------------------------------------
module bpa_word_unit import bpa_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int KW = CNT_W + 1,
	localparam int LW = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0] data,
	input  logic [LW-1:0]        lo_b,
	input  logic [LW-1:0]        hi_b,
	input  wu_cmd_t              cmd,
	input  logic [KW-1:0]        run_in,
	input  logic [KW-1:0]        cnt,
	output logic                 found,
	output logic [LW-1:0]        pos,
	output logic [KW-1:0]        run_out,
	output logic [WORD_BITS-1:0] new_word,
	output logic [LW:0]          pop
);

	localparam int WB = WORD_BITS;

	logic [WB-1:0] lo_part;
	logic [WB-1:0] hi_part;
	logic [WB-1:0] range_mask;
	logic [WB-1:0] busy;
	logic          has_l [LW+1][WB];
	logic [LW-1:0] at_l  [LW+1][WB];
	logic [KW-1:0] run_at [WB];
	logic [WB-1:0] hit;

	assign lo_part    = cmd.use_lo ? ({WB{1'b1}} << lo_b) : {WB{1'b1}};
	assign hi_part    = cmd.use_hi ? ({WB{1'b1}} >> (LW'(WB - 1) - hi_b)) : {WB{1'b1}};
	assign range_mask = lo_part & hi_part;
	// pages outside the range count as used for the search
	assign busy       = data | ~range_mask;

	// prefix tree: highest used bit at or below each position
	always_comb begin
		for (int j = 0; j < WB; j++) begin
			has_l[0][j] = busy[j];
			at_l[0][j]  = LW'(j);
		end
		for (int l = 0; l < LW; l++) begin
			for (int j = 0; j < WB; j++) begin
				if (j >= (1 << l) && !has_l[l][j]) begin
					has_l[l+1][j] = has_l[l][j - (1 << l)];
					at_l[l+1][j]  = at_l[l][j - (1 << l)];
				end else begin
					has_l[l+1][j] = has_l[l][j];
					at_l[l+1][j]  = at_l[l][j];
				end
			end
		end
	end

	// free run ending at each bit, carried in from earlier words
	always_comb begin
		for (int j = 0; j < WB; j++) begin
			if (has_l[LW][j]) begin
				run_at[j] = KW'(LW'(j) - at_l[LW][j]);
			end else begin
				run_at[j] = run_in + KW'(j + 1);
			end
			hit[j] = (run_at[j] >= cnt);
		end
	end

	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int j = WB - 1; j >= 0; j--) begin
			if (hit[j]) begin
				found = 1'b1;
				pos   = LW'(j);
			end
		end
	end

	assign run_out  = has_l[LW][WB-1] ? KW'(LW'(WB - 1) - at_l[LW][WB-1])
	                                  : run_in + KW'(WB);
	assign new_word = cmd.set_op ? (data | range_mask) : (data & ~range_mask);
	assign pop      = (LW + 1)'($countones(data & range_mask));

endmodule

@@ design/bitmap_page_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// first-fit contiguous page allocator over a one-bit-per-page used map held
// in a word-wide ram, driven by a small sequencer around one word unit
// ----------------------------------------------------------------------------
//  channel  dir  fields                              transfer
//  req      in   op, page_count, page_index          req.valid && req.ready
//  rsp      out  status, first_page, used_pages      rsp.valid && rsp.ready
//
//  after reset the map is swept once, one word a cycle over all
//  NUM_PAGES/WORD_BITS map words (512 by default), with req.ready low
//  allocate: scan map words from the hint word up, with no wrap, until a
//  run fits, then set the run word by word; free: clear the run word by word
//  a rejected request goes straight to the response; the map is walked
//  via the single ram read port, one word per cycle through the word unit
//  one request at a time; the next is taken while a response waits in rsp
// ----------------------------------------------------------------------------
module bitmap_page_allocator import bpa_pkg::*; #(
	parameter int NUM_PAGES      = NUM_PAGES_DEF,
	parameter int WORD_BITS      = WORD_BITS_DEF,    // power of two
	parameter int RESERVED_PAGES = RESERVED_PAGES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bpa_req_if.sink      req,
	bpa_rsp_if.source    rsp
);

`include "bitmap_page_allocator_defines.svh"

	localparam int WB        = WORD_BITS;
	localparam int LW        = $clog2(WB);
	localparam int MAP_WORDS = (NUM_PAGES + WB - 1) / WB;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PW        = $clog2(NUM_PAGES);
	localparam int CW        = $clog2(NUM_PAGES + 1);
	localparam int KW        = ((CW > CNT_W) ? CW : CNT_W) + 1;
	localparam int EW        = ((AW + LW > KW) ? AW + LW : KW) + 1;
	localparam int RES_TOP   = (RESERVED_PAGES < NUM_PAGES) ? RESERVED_PAGES : NUM_PAGES;
	localparam int RES_W     = RES_TOP / WB;
	localparam int RES_B     = RES_TOP % WB;
	localparam logic [WB-1:0] RES_PART  = ~({WB{1'b1}} << RES_B);
	localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

	bpa_state_t    state_q, state_nxt;
	logic [AW-1:0] word_q;
	logic [AW-1:0] word_next;
	logic [KW-1:0] run_q;
	logic [KW-1:0] cnt_q;
	logic          set_q;
	logic [PW-1:0] lo_q;
	logic [PW-1:0] hi_q;
	logic [CW-1:0] hint_q;
	logic [CW-1:0] used_q;
	bpa_status_t   stat_q;
	logic [PW-1:0] first_q;

	logic              rsp_valid_q;
	bpa_status_t       rsp_status_q;
	logic [PAGE_W-1:0] rsp_first_q;
	logic [CNT_W-1:0]  rsp_used_q;

	// request decode
	logic          req_xfer;
	logic          cnt_zero;
	logic [EW-1:0] free_end;
	logic          past_end;
	logic          hint_full;

	// word unit and ram
	wu_cmd_t       wu_cmd;
	logic          wu_found;
	logic [LW-1:0] wu_pos;
	logic [KW-1:0] wu_run;
	logic [WB-1:0] wu_new;
	logic [LW:0]   wu_pop;
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [WB-1:0] ram_wdata;
	logic [WB-1:0] ram_rdata;
	logic [WB-1:0] init_word;

	logic [AW-1:0] lo_word;
	logic [AW-1:0] hi_word;
	logic [EW-1:0] end_page;
	logic [EW-1:0] first_calc;
	logic [CW-1:0] used_sub;
	logic          last_apply;
	logic          rsp_free;

	assign req_xfer  = req.valid && req.ready;
	assign cnt_zero  = (req.page_count == '0);
	assign free_end  = EW'(req.page_index) + EW'(req.page_count);
	assign past_end  = (free_end > EW'(NUM_PAGES));
	assign hint_full = (hint_q >= CW'(NUM_PAGES));

	assign lo_word    = AW'(lo_q >> LW);
	assign hi_word    = AW'(hi_q >> LW);
	assign word_next  = (word_q == LAST_WORD) ? word_q : word_q + AW'(1);
	assign end_page   = EW'({word_q, wu_pos});
	assign first_calc = end_page + EW'(1) - EW'(cnt_q);
	assign used_sub   = (used_q > CW'(wu_pop)) ? used_q - CW'(wu_pop) : '0;
	assign last_apply = (word_q == hi_word);
	assign rsp_free   = !rsp_valid_q || rsp.ready;

	assign init_word = (32'(word_q) < RES_W) ? {WB{1'b1}} :
	                   (32'(word_q) == RES_W) ? RES_PART : '0;

	assign wu_cmd.use_lo = (word_q == lo_word);
	assign wu_cmd.use_hi = (word_q == hi_word);
	assign wu_cmd.set_op = set_q;

	bpa_word_unit #(
		.WORD_BITS (WB),
		.KW        (KW)
	) u_word_unit (
		.data     (ram_rdata),
		.lo_b     (lo_q[LW-1:0]),
		.hi_b     (hi_q[LW-1:0]),
		.cmd      (wu_cmd),
		.run_in   (run_q),
		.cnt      (cnt_q),
		.found    (wu_found),
		.pos      (wu_pos),
		.run_out  (wu_run),
		.new_word (wu_new),
		.pop      (wu_pop)
	);

	bpa_ram #(
		.WIDTH (WB),
		.DEPTH (MAP_WORDS)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (word_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_INIT: begin
				if (word_q == LAST_WORD) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_xfer) begin
					if (cnt_zero) begin
						state_nxt = ST_DONE;
					end else if (req.op == OP_ALLOC) begin
						state_nxt = hint_full ? ST_DONE : ST_SCAN_RD;
					end else begin
						state_nxt = past_end ? ST_DONE : ST_APPLY_RD;
					end
				end
			end
			ST_SCAN_RD: state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (wu_found) begin
					state_nxt = ST_APPLY_RD;
				end else if (word_q == LAST_WORD) begin
					state_nxt = ST_DONE;
				end
			end
			ST_APPLY_RD: state_nxt = ST_APPLY;
			ST_APPLY: begin
				if (last_apply) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_INIT;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = wu_new;
		ram_raddr = word_q;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = init_word;
			end
			ST_IDLE: req.ready = 1'b1;
			ST_SCAN: ram_raddr = word_next;
			ST_APPLY: begin
				ram_we    = 1'b1;
				ram_raddr = word_next;
			end
			default: begin
				ram_raddr = word_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			word_q  <= '0;
			hint_q  <= '0;
			used_q  <= CW'(RES_TOP);
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_INIT: begin
					word_q <= word_next;
				end
				ST_IDLE: begin
					if (req_xfer && !cnt_zero) begin
						if (req.op == OP_ALLOC) begin
							word_q <= AW'(hint_q >> LW);
						end else begin
							word_q <= AW'(req.page_index >> LW);
						end
					end
				end
				ST_SCAN: begin
					if (wu_found) begin
						word_q <= AW'(first_calc >> LW);
					end else begin
						word_q <= word_next;
					end
				end
				ST_APPLY: begin
					if (!last_apply) begin
						word_q <= word_next;
					end
					if (!set_q) begin
						used_q <= used_sub;
					end
					if (last_apply) begin
						if (set_q) begin
							used_q <= used_q + CW'(cnt_q);
							hint_q <= CW'(hi_q) + CW'(1);
						end else if (hint_q > CW'(lo_q)) begin
							hint_q <= CW'(lo_q);
						end
					end
				end
				default: begin
					word_q <= word_q;
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					cnt_q   <= KW'(req.page_count);
					set_q   <= (req.op == OP_ALLOC);
					run_q   <= '0;
					first_q <= '0;
					if (req.op == OP_ALLOC) begin
						lo_q <= PW'(hint_q);
						hi_q <= PW'(NUM_PAGES - 1);
					end else begin
						lo_q <= PW'(req.page_index);
						hi_q <= PW'(free_end - EW'(1));
					end
					if (cnt_zero || (req.op == OP_FREE && past_end)) begin
						stat_q <= STAT_BAD;
					end else if (req.op == OP_ALLOC && hint_full) begin
						stat_q <= STAT_NOMEM;
					end else begin
						stat_q <= STAT_OK;
					end
				end
			end
			ST_SCAN: begin
				run_q <= wu_run;
				if (wu_found) begin
					lo_q    <= PW'(first_calc);
					hi_q    <= PW'(end_page);
					first_q <= PW'(first_calc);
				end else if (word_q == LAST_WORD) begin
					stat_q <= STAT_NOMEM;
				end
			end
			default: begin
				run_q <= run_q;
			end
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && rsp_free) begin
			rsp_status_q <= stat_q;
			rsp_first_q  <= PAGE_W'(first_q);
			rsp_used_q   <= CNT_W'(used_q);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.first_page = rsp_first_q;
	assign rsp.used_pages = rsp_used_q;

	`BPA_ASSERT_IMP(a_used_bound, 1'b1, used_q <= CW'(NUM_PAGES), "used count above page total")
	`BPA_ASSERT_IMP(a_hint_bound, 1'b1, hint_q <= CW'(NUM_PAGES), "search hint above page total")
	`BPA_ASSERT_IMP(a_apply_window, state_q == ST_APPLY, word_q >= lo_word && word_q <= hi_word, "apply word outside run")
	`BPA_ASSERT_NXT(a_found_marks, state_q == ST_SCAN && wu_found, state_q == ST_APPLY_RD && set_q, "found run not marked")
	`BPA_ASSERT_NXT(a_result_load, state_q == ST_DONE && rsp_free, rsp_valid_q && state_q == ST_IDLE, "result not presented")

endmodule

@@ bench/tb_bitmap_page_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator
// self-checking bench for the first-fit page allocator: a bit-level copy of
// the used map, hint and page count predicts every response, directed cases
// cover the edges of the map and random alloc/free traffic runs on top
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator import bpa_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PAGES      = NUM_PAGES_DEF;
	localparam int RESERVED_PAGES = RESERVED_PAGES_DEF;
	localparam int RANDOM_ITEMS   = 400;
	localparam int IDLE_LIMIT     = 10000;
	localparam int DRAIN_CYCLES   = 1100;

	typedef struct {
		bpa_status_t       status;
		logic [PAGE_W-1:0] first_page;
		logic [CNT_W-1:0]  used_pages;
	} alloc_result_t;

	typedef struct {
		int start;
		int len;
	} page_run_t;

	class alloc_scoreboard;
		bit [NUM_PAGES-1:0] page_map;
		logic [CNT_W-1:0]   hint;
		logic [CNT_W-1:0]   pages_in_use;
		alloc_result_t      pending_results[$];
		int                 errors;

		function new();
			page_map = '0;
			for (int p = 0; p < RESERVED_PAGES && p < NUM_PAGES; p++) begin
				page_map[p] = 1'b1;
			end
			hint = '0;
			pages_in_use = CNT_W'(RESERVED_PAGES < NUM_PAGES ? RESERVED_PAGES : NUM_PAGES);
			errors = 0;
		endfunction

		function alloc_result_t predict_request(bpa_op_t op, logic [CNT_W-1:0] cnt,
				logic [PAGE_W-1:0] idx);
			alloc_result_t res;
			int run;
			int last;
			int run_start;
			bit found;
			res.status = STAT_OK;
			res.first_page = '0;
			run = 0;
			last = 0;
			found = 1'b0;
			if (cnt == 0) begin
				res.status = STAT_BAD;
			end else if (op == OP_ALLOC) begin
				// first fit from the hint upwards, no wrap
				for (int p = int'(hint); p < NUM_PAGES && !found; p++) begin
					if (page_map[p]) begin
						run = 0;
					end else begin
						run++;
						if (run == int'(cnt)) begin
							found = 1'b1;
							last = p;
						end
					end
				end
				if (!found) begin
					res.status = STAT_NOMEM;
				end else begin
					run_start = last + 1 - int'(cnt);
					for (int p = run_start; p <= last; p++) begin
						page_map[p] = 1'b1;
					end
					hint = CNT_W'(last + 1);
					pages_in_use = pages_in_use + cnt;
					res.first_page = PAGE_W'(run_start);
				end
			end else if (int'(idx) + int'(cnt) > NUM_PAGES) begin
				res.status = STAT_BAD;
			end else begin
				// only pages that were really in use count down
				for (int p = int'(idx); p < int'(idx) + int'(cnt); p++) begin
					if (page_map[p]) begin
						page_map[p] = 1'b0;
						if (pages_in_use > 0) begin
							pages_in_use = pages_in_use - 1'b1;
						end
					end
				end
				if (hint > CNT_W'(idx)) begin
					hint = CNT_W'(idx);
				end
			end
			res.used_pages = pages_in_use;
			pending_results.push_back(res);
			return res;
		endfunction

		function void check_response(alloc_result_t got);
			alloc_result_t exp;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response status %0d first_page %0d used_pages %0d",
					$time, got.status, got.first_page, got.used_pages);
				errors++;
				return;
			end
			exp = pending_results.pop_front();
			if (got.status !== exp.status) begin
				$display("%0t: status mismatch, expected %0d actual %0d",
					$time, exp.status, got.status);
				errors++;
			end
			if (got.first_page !== exp.first_page) begin
				$display("%0t: first_page mismatch, expected %0d actual %0d",
					$time, exp.first_page, got.first_page);
				errors++;
			end
			if (got.used_pages !== exp.used_pages) begin
				$display("%0t: used_pages mismatch, expected %0d actual %0d",
					$time, exp.used_pages, got.used_pages);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   idle_cycles;

	alloc_scoreboard ledger = new();
	page_run_t       live_runs[$];
	alloc_result_t   pick_result;

	bpa_req_if req_ch();
	bpa_rsp_if rsp_ch();

	bitmap_page_allocator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// stall count is drawn per transfer; calm stretches run without gaps
	task automatic send_request(input bpa_op_t op, input logic [CNT_W-1:0] cnt,
			input logic [PAGE_W-1:0] idx, output alloc_result_t res);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.op         <= op;
		req_ch.page_count <= cnt;
		req_ch.page_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		res = ledger.predict_request(op, cnt, idx);
	endtask

	task automatic req_alloc(input logic [CNT_W-1:0] cnt);
		alloc_result_t res;
		send_request(OP_ALLOC, cnt, PAGE_W'($urandom_range(0, NUM_PAGES - 1)), res);
		if (res.status == STAT_OK) begin
			live_runs.push_back(page_run_t'{int'(res.first_page), int'(cnt)});
		end
	endtask

	task automatic req_free(input logic [CNT_W-1:0] cnt, input logic [PAGE_W-1:0] idx);
		alloc_result_t res;
		send_request(OP_FREE, cnt, idx, res);
	endtask

	// response side
	initial begin
		int stall;
		alloc_result_t got;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = calm ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got.status     = rsp_ch.status;
			got.first_page = rsp_ch.first_page;
			got.used_pages = rsp_ch.used_pages;
			ledger.check_response(got);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int sel;
		int k;
		int start;
		int len;
		page_run_t pick;
		calm = 1'b0;
		idle_cycles = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_ALLOC;
		req_ch.page_count = '0;
		req_ch.page_index = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// directed: zero counts, edges of the map, hint at the top
		req_alloc(15'd0);
		req_free(15'd0, 14'h3fff);
		req_alloc(15'd1);
		req_alloc(15'd16);
		req_free(15'd1, 14'd16383);
		req_free(15'd2, 14'd16383);
		req_free(15'h7fff, 14'd0);
		req_alloc(15'h7fff);
		req_alloc(15'd16384);
		req_free(15'd250, 14'd10);
		req_free(15'd16384, 14'd0);
		req_alloc(15'd16384);
		req_alloc(15'd1);
		req_free(15'd10, 14'd100);
		req_alloc(15'd5);
		req_alloc(15'd6);
		req_alloc(15'd5);
		req_free(15'd8192, 14'd8192);
		req_alloc(15'd8192);
		req_free(15'd16384, 14'd0);
		req_alloc(15'd16383);
		req_alloc(15'd1);
		req_free(15'd16384, 14'd0);
		req_alloc(15'd256);
		live_runs.delete();

		// random traffic, mostly alloc and free of runs handed out earlier
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				k = $urandom_range(0, 99);
				if (k < 70) begin
					req_alloc(CNT_W'($urandom_range(1, 32)));
				end else if (k < 90) begin
					req_alloc(CNT_W'($urandom_range(33, 512)));
				end else if (k < 98) begin
					req_alloc(CNT_W'($urandom_range(513, 4096)));
				end else begin
					req_alloc(CNT_W'($urandom_range(0, 32767)));
				end
			end else if (sel < 80 && live_runs.size() != 0) begin
				k = $urandom_range(0, live_runs.size() - 1);
				pick = live_runs[k];
				live_runs.delete(k);
				if ($urandom_range(0, 4) == 0) begin
					// part of a run, the rest stays in use
					start = pick.start + $urandom_range(0, pick.len - 1);
					len = $urandom_range(1, pick.start + pick.len - start);
				end else begin
					start = pick.start;
					len = pick.len;
				end
				req_free(CNT_W'(len), PAGE_W'(start));
			end else if (sel == 99) begin
				req_free(15'd16384, 14'd0);
				live_runs.delete();
			end else begin
				// noise: any field pattern, zero counts, runs past the end
				k = $urandom_range(0, 3);
				if (k == 0) begin
					len = 0;
				end else if (k == 1) begin
					len = $urandom_range(0, 32767);
				end else begin
					len = $urandom_range(1, 64);
				end
				send_request(bpa_op_t'($urandom_range(0, 1)), CNT_W'(len),
					PAGE_W'($urandom_range(0, NUM_PAGES - 1)), pick_result);
			end
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (ledger.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/bpa_pkg.sv
design/bpa_req_if.sv
design/bpa_rsp_if.sv
design/bpa_ram.sv
design/bpa_word_unit.sv
design/bitmap_page_allocator.sv
bench/tb_bitmap_page_allocator.sv
